FILE: rtl/plc_pkg.sv
// Shared constants, codes and the per-cycle command type for the positional list engine.
package plc_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_HEAD = 3'd0,
        KIND_INS_TAIL = 3'd1,
        KIND_INS_AT   = 3'd2,
        KIND_EXT_HEAD = 3'd3,
        KIND_EXT_TAIL = 3'd4,
        KIND_EXT_AT   = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed {
        logic               ins;
        logic               ext;
        logic [CMP_W-1:0]   idx;
        logic [VAL_W-1:0]   value;
    } t_op;

endpackage

FILE: rtl/positional_list_engine.sv
// Top level of the positional list engine: request decoder, cell chain and result register.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit values. A request on the
// slave stream carries an operation kind in s_axis_tuser and a value and position in
// s_axis_tdata: insert at the head, at the tail or before a position, or extract from
// the head, the tail or a position. Every request yields exactly one result on the master
// stream: the extracted value (zero unless an extract succeeds), a status (ok, full,
// empty, position out of range) and the element count after the request.
// Each element lives in its own cell of a chain. On a successful insert every cell past
// the target copies its lower neighbor; on an extract every cell from the target on
// copies its upper neighbor, so all elements move in the same cycle as the request.
// The result is registered and appears in the cycle after its request is taken; one request
// is taken per cycle while the receiver keeps up, as the chain and count update together.
// When the receiver stalls, the result register holds its contents and a new request is
// taken only in a cycle in which that register is empty or being drained.
// Reset empties the list and drops any pending result; stored values need no clearing
// because cells beyond the count are never read.
module positional_list_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [2:0]   s_axis_tuser,   // kind[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata    // extracted_value[31:0], status[33:32],
                                         // element_count[38:34], zero pad
);
    import plc_pkg::*;

    logic                 w_fire;
    t_op                  w_op;
    t_status              w_status;
    logic [VAL_W-1:0]     w_data [DEPTH];
    logic [VAL_W-1:0]     w_acc  [DEPTH+1];

    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_ext_value;
    t_status              r_status;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    // A new request may enter whenever the result register is free or being taken.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    plc_ctrl u_ctrl (
        .i_kind     (s_axis_tuser),
        .i_value    (s_axis_tdata[VAL_W-1:0]),
        .i_position (s_axis_tdata[VAL_W+POS_W-1:VAL_W]),
        .i_count    (r_count),
        .i_fire     (w_fire),
        .o_op       (w_op),
        .o_status   (w_status)
    );

    // The extract accumulator runs from the top cell down to cell zero.
    assign w_acc[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        plc_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_idx   (CMP_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_acc   (w_acc[g+1]),
            .o_data  (w_data[g]),
            .o_acc   (w_acc[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_op.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_op.ext) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; it is loaded only when a request is taken.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_ext_value <= w_acc[0];
            r_status    <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(40 - VAL_W - STAT_W - CNT_W){1'b0}},
                            r_count, r_status, r_ext_value};

    // The element count never passes the list capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    // Without an accepted request the list length does not change.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_count))
        else $error("element count changed without a request");

    // A request moves the count by at most one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_count == $past(r_count)) ||
                   (r_count == $past(r_count) + CNT_W'(1)) ||
                   (r_count == $past(r_count) - CNT_W'(1)))
        else $error("element count moved by more than one");

    // A failed request never returns a stored value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |-> (r_ext_value == '0))
        else $error("nonzero value returned with an error status");

endmodule

FILE: rtl/plc_cell.sv
// One storage cell of the list chain: holds one element and trades it with its neighbors.
module plc_cell (
    input  logic                         i_clk,
    input  plc_pkg::t_op                 i_op,
    input  logic [plc_pkg::CMP_W-1:0]    i_idx,
    input  logic [plc_pkg::VAL_W-1:0]    i_left,
    input  logic [plc_pkg::VAL_W-1:0]    i_right,
    input  logic [plc_pkg::VAL_W-1:0]    i_acc,
    output logic [plc_pkg::VAL_W-1:0]    o_data,
    output logic [plc_pkg::VAL_W-1:0]    o_acc
);
    import plc_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (i_idx > i_op.idx) begin
                n_data = i_left;
            end else if (i_idx == i_op.idx) begin
                n_data = i_op.value;
            end
        end else if (i_op.ext && (i_idx >= i_op.idx)) begin
            n_data = i_right;
        end
    end

    // The extracted element is picked up as the accumulator passes this cell.
    assign o_acc  = i_acc | ((i_op.ext && (i_idx == i_op.idx)) ? r_data : '0);
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

FILE: rtl/plc_ctrl.sv
// Request decoder: checks a request against the element count and builds the chain command.
module plc_ctrl (
    input  logic [plc_pkg::KIND_W-1:0]   i_kind,
    input  logic [plc_pkg::VAL_W-1:0]    i_value,
    input  logic [plc_pkg::POS_W-1:0]    i_position,
    input  logic [plc_pkg::CNT_W-1:0]    i_count,
    input  logic                         i_fire,
    output plc_pkg::t_op                 o_op,
    output plc_pkg::t_status             o_status
);
    import plc_pkg::*;

    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_pos;
    logic             w_full;
    logic             w_empty;
    logic             w_ins;
    logic             w_ext;
    logic [CMP_W-1:0] w_idx;

    assign w_cnt   = CMP_W'(i_count);
    assign w_pos   = CMP_W'(i_position);
    assign w_full  = (i_count == CNT_W'(DEPTH));
    assign w_empty = (i_count == '0);

    always_comb begin
        w_ins    = 1'b0;
        w_ext    = 1'b0;
        w_idx    = '0;
        o_status = ST_OK;
        case (t_kind'(i_kind))
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AT: begin
                w_ins = 1'b1;
                if (t_kind'(i_kind) == KIND_INS_TAIL) begin
                    w_idx = w_cnt;
                end else if (t_kind'(i_kind) == KIND_INS_AT) begin
                    w_idx = w_pos;
                end
                if (w_full) begin
                    o_status = ST_FULL;
                end else if (w_idx > w_cnt) begin
                    o_status = ST_RANGE;
                end
            end
            KIND_EXT_HEAD, KIND_EXT_TAIL, KIND_EXT_AT: begin
                w_ext = 1'b1;
                if (t_kind'(i_kind) == KIND_EXT_TAIL) begin
                    w_idx = w_cnt - CMP_W'(1);
                end else if (t_kind'(i_kind) == KIND_EXT_AT) begin
                    w_idx = w_pos;
                end
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (w_idx >= w_cnt) begin
                    o_status = ST_RANGE;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

    // Only an accepted request that passes its checks moves the chain.
    assign o_op.ins   = i_fire && w_ins && (o_status == ST_OK);
    assign o_op.ext   = i_fire && w_ext && (o_status == ST_OK);
    assign o_op.idx   = w_idx;
    assign o_op.value = i_value;

endmodule

FILE: tb/tb_positional_list_engine.sv
// Self-checking stream testbench for the positional list engine.
`timescale 1ns / 100ps

module tb_positional_list_engine;

    import plc_pkg::*;

    // Kinds six and seven are not decoded by the block and must leave the list alone.
    localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

    localparam logic [VAL_W-1:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_ZERO     = 32'h0000_0000;

    localparam int RANDOM_OPS   = 1800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // One predicted response: the fields packed into m_axis_tdata.
    typedef struct {
        logic [VAL_W-1:0] got;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_list_result;

    // Shadow copy of the list plus the queue of responses still owed by the block.
    class list_shadow;
        logic [VAL_W-1:0] slots [DEPTH];
        int unsigned      fill;
        t_list_result     owed_results [$];
        int unsigned      mismatch_count;

        function new();
            fill           = 0;
            mismatch_count = 0;
        endfunction

        function t_status shift_in(int unsigned pos, logic [VAL_W-1:0] val);
            int unsigned i;
            if (fill >= DEPTH) return ST_FULL;
            if (pos > fill) return ST_RANGE;
            for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = val;
            fill++;
            return ST_OK;
        endfunction

        function t_status shift_out(int unsigned pos, output logic [VAL_W-1:0] got);
            int unsigned i;
            got = '0;
            if (fill == 0) return ST_EMPTY;
            if (pos >= fill) return ST_RANGE;
            got = slots[pos];
            for (i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
            return ST_OK;
        endfunction

        // Applies an accepted request to the shadow list and queues the response it owes.
        function void note_request(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] val,
                                   logic [POS_W-1:0] pos);
            t_list_result     r;
            logic [VAL_W-1:0] got;
            got      = '0;
            r.status = ST_OK;
            case (kind)
                KIND_INS_HEAD: r.status = shift_in(0, val);
                KIND_INS_TAIL: r.status = shift_in(fill, val);
                KIND_INS_AT:   r.status = shift_in(pos, val);
                KIND_EXT_HEAD: r.status = shift_out(0, got);
                KIND_EXT_TAIL: begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else r.status = shift_out(fill - 1, got);
                end
                KIND_EXT_AT:   r.status = shift_out(pos, got);
                default: ;
            endcase
            r.got   = got;
            r.count = CNT_W'(fill);
            owed_results.push_back(r);
        endfunction

        // Compares one response beat against the oldest owed response.
        function void check_result(logic [39:0] beat);
            t_list_result     want;
            logic [VAL_W-1:0] got_v;
            logic [STAT_W-1:0] st_v;
            logic [CNT_W-1:0] cnt_v;
            got_v = beat[31:0];
            st_v  = beat[33:32];
            cnt_v = beat[38:34];
            if (owed_results.size() == 0) begin
                $error("response with no request outstanding: tdata=%h", beat);
                mismatch_count++;
                return;
            end
            want = owed_results.pop_front();
            if (got_v !== want.got) begin
                $error("extracted_value: expected %0d, actual %0d",
                       $signed(want.got), $signed(got_v));
                mismatch_count++;
            end
            if (st_v !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st_v);
                mismatch_count++;
            end
            if (cnt_v !== want.count) begin
                $error("element_count: expected %0d, actual %0d", want.count, cnt_v);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // value[31:0], position[36:32], zero pad
    logic [2:0]  s_axis_tuser;   // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // extracted_value[31:0], status[33:32],
                                 // element_count[38:34], zero pad

    list_shadow shadow;

    positional_list_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 39))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return VAL_ALL_ONES;
            3:       return VAL_ZERO;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions for the current fill, the rest anywhere in the 5-bit field.
    function automatic logic [POS_W-1:0] pick_position(logic [KIND_W-1:0] kind,
                                                       int unsigned fill);
        bit legal;
        legal = ($urandom_range(0, 99) < 85);
        if (legal && kind == KIND_INS_AT) return POS_W'($urandom_range(0, fill));
        if (legal && kind == KIND_EXT_AT && fill > 0)
            return POS_W'($urandom_range(0, fill - 1));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // Presents one request after an optional idle gap and waits for it to be taken.
    // tvalid stays high across back-to-back requests so it is written once per edge.
    task automatic send_request(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] val,
                                logic [POS_W-1:0] pos, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, pos, val};
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.note_request(kind, val, pos);
    endtask

    // Response side: checks every accepted beat and throttles tready with stalls of
    // random length, interleaved with short ready runs and long always-ready stretches.
    initial begin
        int          ready_run;
        int unsigned pick;
        ready_run = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) shadow.check_result(m_axis_tdata);
            if (ready_run > 0) begin
                ready_run--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    ready_run = rand_gap();
                    m_axis_tready <= 1'b0;
                end else if (pick < 45) begin
                    ready_run = $urandom_range(40, 150);
                    m_axis_tready <= 1'b1;
                end else begin
                    ready_run = $urandom_range(0, 12);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run once neither side has moved a beat for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int unsigned       op_count;
        int unsigned       pick;
        int unsigned       grow_pct;
        int                burst_left;
        int                gap;
        int                i;
        bit                grow;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;

        shadow = new();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_rst_n       <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, the range check on insert, extreme values, filling up,
        // the full check ahead of the range check, extract range, reserved kinds.
        send_request(KIND_EXT_HEAD, pick_value(), 5'd0, 0);
        send_request(KIND_EXT_TAIL, pick_value(), 5'd0, rand_gap());
        send_request(KIND_EXT_AT, pick_value(), 5'd0, 0);
        send_request(KIND_INS_AT, VAL_MAX, 5'd1, 0);
        send_request(KIND_INS_HEAD, VAL_MIN, 5'd0, 0);
        send_request(KIND_INS_TAIL, VAL_MAX, 5'd0, rand_gap());
        send_request(KIND_INS_AT, VAL_ALL_ONES, 5'd1, 0);
        send_request(KIND_INS_AT, VAL_ZERO, 5'd3, 0);
        for (i = 0; i < 12; i++) begin
            kind = (i % 3 == 0) ? KIND_INS_HEAD : (i % 3 == 1) ? KIND_INS_TAIL : KIND_INS_AT;
            send_request(kind, $urandom, pick_position(KIND_INS_AT, shadow.fill), rand_gap());
        end
        send_request(KIND_INS_HEAD, pick_value(), 5'd0, 0);
        send_request(KIND_INS_AT, pick_value(), 5'd31, 0);
        send_request(KIND_EXT_AT, pick_value(), 5'd16, rand_gap());
        send_request(KIND_EXT_AT, pick_value(), 5'd31, 0);
        send_request(KIND_EXT_AT, pick_value(), 5'd15, 0);
        send_request(KIND_RSVD_6, pick_value(), 5'd7, 0);
        send_request(KIND_RSVD_7, pick_value(), 5'd31, rand_gap());
        send_request(KIND_EXT_AT, pick_value(), 5'd5, 0);
        send_request(KIND_EXT_TAIL, pick_value(), 5'd0, 0);
        send_request(KIND_EXT_HEAD, pick_value(), 5'd0, 0);

        // Random: the list swings between filling and draining so that full and empty
        // are both reached often, with the odd reserved kind mixed in.
        op_count   = 0;
        burst_left = 0;
        grow       = 1'b0;
        while (op_count < RANDOM_OPS) begin
            if (shadow.fill >= DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
            if (shadow.fill == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
            if ($urandom_range(0, 63) == 0) grow = ~grow;
            grow_pct = grow ? 74 : 34;
            pick     = $urandom_range(0, 99);
            if (pick < 4)
                kind = pick[0] ? KIND_RSVD_7 : KIND_RSVD_6;
            else if (pick < grow_pct)
                kind = KIND_W'($urandom_range(KIND_INS_HEAD, KIND_INS_AT));
            else
                kind = KIND_W'($urandom_range(KIND_EXT_HEAD, KIND_EXT_AT));
            pos = pick_position(kind, shadow.fill);
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = rand_gap();
                if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
            end
            send_request(kind, pick_value(), pos, gap);
            if (kind != KIND_RSVD_6 && kind != KIND_RSVD_7) op_count++;
        end
        s_axis_tvalid <= 1'b0;

        while (shadow.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.mismatch_count == 0 && shadow.owed_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
